>>> hw/rtl/wsld_pkg.sv
package wsld_pkg;

  localparam int WINDOW      = 60;
  localparam int MIN_SAMPLES = 10;

  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SLOT_W = $clog2(WINDOW);

  localparam int UW     = 36;
  localparam int GW     = 37;
  localparam int RW     = 63;
  localparam int SV_W   = 42;
  localparam int SW_W   = 48;
  localparam int MAG_W  = 53;
  localparam int SX_W   = 11;
  localparam int DD_W   = 21;
  localparam int IV_W   = 27;
  localparam int WP_W   = 7;
  localparam int LIM_W  = 32;
  localparam int DEN_W  = 48;
  localparam int K_W    = 24;
  localparam int PROD_W = 77;
  localparam int LO_W   = 27;
  localparam int WARN_W = UW + WP_W;
  localparam int CNT_W  = $clog2(PROD_W);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_FREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd4;

  localparam logic [IV_W-1:0]  RST_INTERVAL = 27'd5000;
  localparam logic [WP_W-1:0]  RST_WARN     = 7'd75;
  localparam logic [LIM_W-1:0] RST_LIMIT    = 32'd1024;
  localparam logic [LIM_W-1:0] RST_LOW_FREE = 32'd524288;

  // 60000 ms per minute times 256 for the fraction bits.
  localparam logic [K_W-1:0]    RATE_K       = 24'd15360000;
  localparam logic [RW-1:0]     RATE_MAX     = 63'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [PROD_W-1:0] RATE_MIN_MAG = PROD_W'(64'h4000_0000_0000_0000);

  typedef struct packed {
    logic load;
    logic rd;
    logic upd;
    logic ma;
    logic mb;
    logic mc;
    logic mk0;
    logic mk1;
    logic div_step;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic few;
  } stat_t;

  // Sum of positions 0..n-1.
  function automatic logic [SX_W-1:0] sx_of(input logic [FILL_W-1:0] n);
    logic [31:0] t;
    t = (32'(n) * (32'(n) - 32'd1)) >> 1;
    return SX_W'(t);
  endfunction

  // Least-squares denominator n*n*(n*n-1)/12, looked up from a table of
  // constants over every possible fill.
  function automatic logic [DD_W-1:0] dd_of(input logic [FILL_W-1:0] n);
    logic [63:0] t;
    t = '0;
    for (int i = 0; i <= WINDOW; i++) begin
      if (n == FILL_W'(i)) begin
        t = (64'(i) * 64'(i) * (64'(i) * 64'(i) - 64'd1)) / 64'd12;
      end
    end
    return DD_W'(t);
  endfunction

endpackage

>>> hw/rtl/wsld_ctrl.sv
module wsld_ctrl
  import wsld_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  logic  in_action,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_RD   = 10'b00_0000_0010,
    S_UPD  = 10'b00_0000_0100,
    S_MA   = 10'b00_0000_1000,
    S_MB   = 10'b00_0001_0000,
    S_MC   = 10'b00_0010_0000,
    S_MK0  = 10'b00_0100_0000,
    S_MK1  = 10'b00_1000_0000,
    S_DIV  = 10'b01_0000_0000,
    S_FIN  = 10'b10_0000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = in_action ? S_FIN : S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_MA;
      end
      S_MA: begin
        cmd.ma    = 1'b1;
        state_nxt = stat.few ? S_FIN : S_MB;
      end
      S_MB: begin
        cmd.mb    = 1'b1;
        state_nxt = S_MC;
      end
      S_MC: begin
        cmd.mc    = 1'b1;
        state_nxt = S_MK0;
      end
      S_MK0: begin
        cmd.mk0   = 1'b1;
        state_nxt = S_MK1;
      end
      S_MK1: begin
        cmd.mk1   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(PROD_W - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted request did not start work");

  a_valid_rises_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result appeared outside the finish step");

  a_div_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < CNT_W'(PROD_W)))
    else $error("divider ran past its last step");

endmodule

>>> hw/rtl/wsld_datapath.sv
module wsld_datapath
  import wsld_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_action,
  input  logic [UW-1:0]         in_usage_kb,
  input  logic [UW-1:0]         in_total_kb,
  input  logic [UW-1:0]         in_free_kb,
  output logic signed [GW-1:0]  out_growth_kb,
  output logic signed [RW-1:0]  out_rate_kb_per_min,
  output logic                  out_leak_flag,
  output logic                  out_usage_warning,
  output logic                  out_low_memory
);

  logic [IV_W-1:0]  interval_r;
  logic [WP_W-1:0]  warn_pct_r;
  logic [LIM_W-1:0] limit_r;
  logic [LIM_W-1:0] low_free_r;
  logic             enable_r;

  logic [UW-1:0]     prev_r;
  logic              has_prev_r;
  logic [FILL_W-1:0] fill_r;
  logic [SLOT_W-1:0] oldest_r;
  logic [SV_W-1:0]   sv_r;
  logic [SW_W-1:0]   sw_r;

  logic          act_r;
  logic [UW-1:0] usage_r, total_r, free_r;
  logic [UW-1:0] old_r;
  logic [UW-1:0] win_mem [WINDOW];

  logic [GW-1:0]     growth_r;
  logic              warn_r, low_r;
  logic [MAG_W-1:0]  a_r, b_r, mag_r;
  logic              neg_r;
  logic [DEN_W-1:0]  den_r, rem_r;
  logic [PROD_W-1:0] dq_r;

  logic              full;
  logic [FILL_W:0]   slot_sum;
  logic [SLOT_W-1:0] wr_slot;
  logic [FILL_W-1:0] fac;
  logic [SW_W-1:0]   wprod;
  logic [IV_W-1:0]   iv;
  logic [DEN_W:0]    trial;
  logic              ge;
  logic [PROD_W-1:0] lim_q;
  logic [RW-1:0]     mag_sat;
  logic [RW-1:0]     rate_val;
  logic              leak_val;
  logic              few;

  assign full     = (fill_r == FILL_W'(WINDOW));
  assign slot_sum = (FILL_W + 1)'(oldest_r) + (FILL_W + 1)'(fill_r);
  assign wr_slot  = full ? oldest_r :
                    (slot_sum >= (FILL_W + 1)'(WINDOW)) ?
                    SLOT_W'(slot_sum - (FILL_W + 1)'(WINDOW)) : SLOT_W'(slot_sum);
  assign fac      = full ? FILL_W'(WINDOW - 1) : fill_r;
  assign wprod    = SW_W'(fac) * SW_W'(usage_r);
  assign iv       = (interval_r == '0) ? IV_W'(1) : interval_r;
  assign few      = (fill_r < FILL_W'(2));
  assign stat.few = few;

  assign trial = {rem_r, dq_r[PROD_W-1]};
  assign ge    = (trial >= {1'b0, den_r});

  // The quotient exceeds limit*256 exactly when the cross product does, with a
  // tie broken by a nonzero remainder.
  assign lim_q = PROD_W'({limit_r, 8'd0});

  always_comb begin
    if (neg_r) begin
      mag_sat  = (dq_r > RATE_MIN_MAG) ? RATE_MIN_MAG[RW-1:0] : dq_r[RW-1:0];
      rate_val = RW'(0) - mag_sat;
    end else begin
      mag_sat  = (dq_r > PROD_W'(RATE_MAX)) ? RATE_MAX : dq_r[RW-1:0];
      rate_val = mag_sat;
    end
    if (few) begin
      rate_val = '0;
    end
    leak_val = enable_r && !few && (32'(fill_r) >= MIN_SAMPLES) && !neg_r &&
               ((dq_r > lim_q) || ((dq_r == lim_q) && (rem_r != '0)));
  end

  // Configuration and window bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= RST_INTERVAL;
      warn_pct_r <= RST_WARN;
      limit_r    <= RST_LIMIT;
      low_free_r <= RST_LOW_FREE;
      enable_r   <= 1'b1;
      prev_r     <= '0;
      has_prev_r <= 1'b0;
      fill_r     <= '0;
      oldest_r   <= '0;
      sv_r       <= '0;
      sw_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INTERVAL: interval_r <= cfg_data[IV_W-1:0];
          CFG_WARN:     warn_pct_r <= cfg_data[WP_W-1:0];
          CFG_LIMIT:    limit_r    <= cfg_data[LIM_W-1:0];
          CFG_LOW_FREE: low_free_r <= cfg_data[LIM_W-1:0];
          CFG_ENABLE:   enable_r   <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.rd) begin
        prev_r     <= usage_r;
        has_prev_r <= 1'b1;
      end
      if (cmd.upd) begin
        if (full) begin
          sw_r     <= sw_r - (SW_W'(sv_r) - SW_W'(old_r)) + wprod;
          sv_r     <= sv_r - SV_W'(old_r) + SV_W'(usage_r);
          oldest_r <= (oldest_r == SLOT_W'(WINDOW - 1)) ? '0 : oldest_r + SLOT_W'(1);
        end else begin
          sw_r   <= sw_r + wprod;
          sv_r   <= sv_r + SV_W'(usage_r);
          fill_r <= fill_r + FILL_W'(1);
        end
      end
      if (cmd.fin && act_r) begin
        fill_r   <= '0;
        oldest_r <= '0;
        sv_r     <= '0;
        sw_r     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      old_r <= win_mem[oldest_r];
    end
    if (cmd.upd) begin
      win_mem[wr_slot] <= usage_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= in_action;
      usage_r <= in_usage_kb;
      total_r <= in_total_kb;
      free_r  <= in_free_kb;
    end
    if (cmd.rd) begin
      growth_r <= has_prev_r ? GW'({1'b0, usage_r} - {1'b0, prev_r}) : '0;
      warn_r   <= (total_r != '0) &&
                  ((WARN_W'(usage_r) * WARN_W'(100)) >
                   (WARN_W'(warn_pct_r) * WARN_W'(total_r)));
      low_r    <= (free_r < UW'(low_free_r));
    end
    if (cmd.ma) begin
      a_r <= MAG_W'(fill_r) * MAG_W'(sw_r);
    end
    if (cmd.mb) begin
      b_r <= MAG_W'(sx_of(fill_r)) * MAG_W'(sv_r);
    end
    if (cmd.mc) begin
      neg_r <= (b_r > a_r);
      mag_r <= (b_r > a_r) ? (b_r - a_r) : (a_r - b_r);
      den_r <= DEN_W'(dd_of(fill_r)) * DEN_W'(iv);
    end
    if (cmd.mk0) begin
      dq_r <= PROD_W'(mag_r[LO_W-1:0]) * PROD_W'(RATE_K);
    end
    if (cmd.mk1) begin
      dq_r  <= dq_r + ((PROD_W'(mag_r[MAG_W-1:LO_W]) * PROD_W'(RATE_K)) << LO_W);
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
      dq_r  <= {dq_r[PROD_W-2:0], ge};
    end
    if (cmd.fin) begin
      if (act_r) begin
        out_growth_kb       <= '0;
        out_rate_kb_per_min <= '0;
        out_leak_flag       <= 1'b0;
        out_usage_warning   <= 1'b0;
        out_low_memory      <= 1'b0;
      end else begin
        out_growth_kb       <= growth_r;
        out_rate_kb_per_min <= rate_val;
        out_leak_flag       <= leak_val;
        out_usage_warning   <= warn_r;
        out_low_memory      <= low_r;
      end
    end
  end

endmodule

>>> hw/rtl/windowed_slope_leak_detector_core.sv
// A clear request goes straight to finishing; a sample with under two held values passes read,
// update and the first product; others also pass the later products, the two scaling halves
// and the 77-step shift-subtract divider. The next request is accepted once the last has
// finished, while its result waits in the output register; finishing waits while a held result
// is stalled. Reset (rst_n, synchronous, active low) restores the register defaults and empties
// the window; the window memory itself is not cleared, so there is no clearing pass.
module windowed_slope_leak_detector_core
  import wsld_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic [UW-1:0]         in_usage_kb,
  input  logic [UW-1:0]         in_total_kb,
  input  logic [UW-1:0]         in_free_kb,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [GW-1:0]  out_growth_kb,
  output logic signed [RW-1:0]  out_rate_kb_per_min,
  output logic                  out_leak_flag,
  output logic                  out_usage_warning,
  output logic                  out_low_memory,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // The controller steps a sample with two or more held values through window update,
  // the three products of the slope, the scaling multiply in two halves and the divider.
  // The datapath holds the window, running sums and result register.
  cmd_t  cmd;
  stat_t stat;

  wsld_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  wsld_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_action           (in_action),
    .in_usage_kb         (in_usage_kb),
    .in_total_kb         (in_total_kb),
    .in_free_kb          (in_free_kb),
    .out_growth_kb       (out_growth_kb),
    .out_rate_kb_per_min (out_rate_kb_per_min),
    .out_leak_flag       (out_leak_flag),
    .out_usage_warning   (out_usage_warning),
    .out_low_memory      (out_low_memory)
  );

endmodule
